[design/cmoi_pkg.sv]
// Shared types and constants for the costmap obstacle inflation block.
// Used by the top level, cmoi_ctrl, cmoi_update and the testbench; depends on nothing.
`timescale 1ns / 1ps

package cmoi_pkg;

  // Input item action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_MARK  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_TABLE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_INFLATION   = 2'd2;

  // Cell cost codes
  localparam logic signed [7:0] COST_UNKNOWN = -8'sd1;
  localparam logic signed [7:0] COST_FREE    = 8'sd0;
  localparam logic signed [7:0] COST_LETHAL  = 8'sd100;
  localparam logic [6:0]        TABLE_LETHAL = 7'd100;

  localparam int TABLE_AW    = 9;
  localparam int TABLE_DEPTH = 512;

  typedef enum logic [2:0] {
    ST_INIT,   // clearing pass after reset, writes unknown
    ST_IDLE,
    ST_FILL,   // clear item, writes free
    ST_SWEEP,  // one neighbor probe per cycle
    ST_DRAIN,  // last update write lands
    ST_READ    // read data present, wait for output slot
  } state_t;

  // One neighbor probe handed from the sequencer to the update stage
  typedef struct packed {
    logic valid;
    logic center;
    logic in_grid;
  } probe_t;

endpackage

[design/costmap_obstacle_inflation.sv]
// Top level of the costmap obstacle inflation block: configuration, memories,
// result register. Depends on cmoi_pkg, cmoi_ram, cmoi_ctrl and cmoi_update.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// config    cfg_we                 cfg_index, cfg_data
// items in  in_valid / in_ready    action, cell_x, cell_y, table_index, table_cost
// results   out_valid / out_ready  cell_cost, read_in_grid
//
// Pacing: the cost grid memory sets the pace, one cell access per cycle.
// A mark in the grid probes (2R+1)^2 cells, R the saturated sweep half-size,
// then lets its last update write land; a read fetches its cell, then waits for
// the result register; a table write or a dropped mark is done on acceptance.
// A clear sweeps every grid entry: 2^(XW+YW) of them, 65536 at the default size.
// Reset: a clearing pass writes unknown into all 2^(XW+YW) cells (65536 by default);
// no item is taken until it ends, config writes are.
// Stalls: a held result blocks nothing until the next read arrives; that read
// waits in the sequencer and holds off all intake until the result register frees.

module costmap_obstacle_inflation #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [7:0]        cell_x,
  input  logic [7:0]        cell_y,
  input  logic [8:0]        table_index,
  input  logic [6:0]        table_cost,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] cell_cost,
  output logic              read_in_grid
);

  import cmoi_pkg::*;

  // Grid cell (x,y) lives at {y, x}; row stride is the next power of two
  localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;

  // Register caps: the ports cannot exceed 511 columns/rows or radius 15
  localparam logic [8:0] W_CAP = (MAX_WIDTH  > 511) ? 9'd511 : 9'(MAX_WIDTH);
  localparam logic [8:0] H_CAP = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);
  localparam logic [3:0] R_CAP = (MAX_RADIUS > 15)  ? 4'd15  : 4'(MAX_RADIUS);

  logic [8:0]     grid_width;
  logic [8:0]     grid_height;
  logic [3:0]     sweep_half;
  logic [8:0]     used_w;
  logic [8:0]     used_h;
  logic [3:0]     used_r;

  logic           out_free;
  logic           rd_load;
  logic           rd_in_grid;
  logic [AW-1:0]  grid_raddr;
  logic [7:0]     grid_rdata;
  logic [8:0]     tbl_raddr;
  logic [6:0]     tbl_rdata;
  probe_t         probe;
  logic           fill_we;
  logic [AW-1:0]  fill_addr;
  logic signed [7:0] fill_val;
  logic           upd_we;
  logic [AW-1:0]  upd_waddr;
  logic [7:0]     upd_wdata;
  logic           grid_we;
  logic [AW-1:0]  grid_waddr;
  logic [7:0]     grid_wdata;
  logic           tbl_we;
  logic [6:0]     tbl_wdata;

  // Configuration registers; user-written only while the block is idle, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 9'd256;
      grid_height <= 9'd256;
      sweep_half  <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_INFLATION:   sweep_half  <= cfg_data[3:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Saturate sizes to 1..MAX and the radius to MAX_RADIUS
  assign used_w = (grid_width == 9'd0) ? 9'd1 : ((grid_width > W_CAP) ? W_CAP : grid_width);
  assign used_h = (grid_height == 9'd0) ? 9'd1 :
                  ((grid_height > H_CAP) ? H_CAP : grid_height);
  assign used_r = (sweep_half > R_CAP) ? R_CAP : sweep_half;

  // Result register frees the sequencer as soon as it is taken
  assign out_free = !out_valid || out_ready;

  cmoi_ctrl #(
    .XW (XW),
    .YW (YW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .used_w     (used_w),
    .used_h     (used_h),
    .radius     (used_r),
    .out_free   (out_free),
    .rd_load    (rd_load),
    .rd_in_grid (rd_in_grid),
    .grid_raddr (grid_raddr),
    .tbl_raddr  (tbl_raddr),
    .probe      (probe),
    .fill_we    (fill_we),
    .fill_addr  (fill_addr),
    .fill_val   (fill_val)
  );

  cmoi_update #(
    .AW (AW)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .probe      (probe),
    .probe_addr (grid_raddr),
    .cur_cost   (grid_rdata),
    .tbl_cost   (tbl_rdata),
    .we         (upd_we),
    .waddr      (upd_waddr),
    .wdata      (upd_wdata)
  );

  // Grid write port: clearing sweeps and sweep updates never overlap
  assign grid_we    = fill_we || upd_we;
  assign grid_waddr = fill_we ? fill_addr : upd_waddr;
  assign grid_wdata = fill_we ? fill_val : upd_wdata;

  cmoi_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  // Decay table: saturate costs to lethal on the way in
  assign tbl_we    = in_valid && in_ready && (action == ACT_TABLE);
  assign tbl_wdata = (table_cost > TABLE_LETHAL) ? TABLE_LETHAL : table_cost;

  cmoi_ram #(
    .WIDTH (7),
    .DEPTH (TABLE_DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (table_index),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Result register; a read outside the grid answers unknown
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (rd_load) begin
      cell_cost    <= rd_in_grid ? $signed(grid_rdata) : COST_UNKNOWN;
      read_in_grid <= rd_in_grid;
    end
  end

`ifndef ASSERT_OFF
  // Clearing sweep and sweep update must never share the grid write port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(fill_we && upd_we))
    else $error("grid write port driven by sweep and update at once");

  // An update write never lands on the cell being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (upd_we && probe.valid) |-> (upd_waddr != grid_raddr))
    else $error("update write collides with sweep read");

  // A result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    rd_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending transaction");
`endif

endmodule

[design/cmoi_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module cmoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/cmoi_ctrl.sv]
// Sequencer: item intake, clearing sweeps, neighbor sweep and read timing.
// Depends on cmoi_pkg.
`timescale 1ns / 1ps

module cmoi_ctrl #(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [7:0]             cell_x,
  input  logic [7:0]             cell_y,
  input  logic [8:0]             used_w,
  input  logic [8:0]             used_h,
  input  logic [3:0]             radius,
  input  logic                   out_free,
  output logic                   rd_load,
  output logic                   rd_in_grid,
  output logic [XW+YW-1:0]       grid_raddr,
  output logic [8:0]             tbl_raddr,
  output cmoi_pkg::probe_t       probe,
  output logic                   fill_we,
  output logic [XW+YW-1:0]       fill_addr,
  output logic signed [7:0]      fill_val
);

  import cmoi_pkg::*;

  localparam int AW = XW + YW;

  state_t              state;
  state_t              state_next;
  logic [7:0]          ox;
  logic [7:0]          oy;
  logic signed [4:0]   dx;
  logic signed [4:0]   dy;
  logic [AW-1:0]       fill_cnt;
  logic                fill_free;
  logic                accept;
  logic                center_in;
  logic signed [4:0]   rs;
  logic                last_col;
  logic                sweep_done;
  logic                fill_done;
  logic signed [9:0]   nx;
  logic signed [9:0]   ny;
  logic                n_in;
  logic [3:0]          adx;
  logic [3:0]          ady;
  logic [7:0]          sqx;
  logic [7:0]          sqy;

  assign accept     = in_valid && (state == ST_IDLE);
  assign center_in  = ({1'b0, cell_x} < used_w) && ({1'b0, cell_y} < used_h);
  assign rs         = $signed({1'b0, radius});
  assign last_col   = (dx == rs);
  assign sweep_done = last_col && (dy == rs);
  assign fill_done  = (fill_cnt == '1);

  // Neighbor coordinates and squared distance
  assign nx   = $signed({2'b00, ox}) + $signed({{5{dx[4]}}, dx});
  assign ny   = $signed({2'b00, oy}) + $signed({{5{dy[4]}}, dy});
  assign n_in = !nx[9] && !ny[9] && (nx[8:0] < used_w) && (ny[8:0] < used_h);
  assign adx  = dx[4] ? 4'(~dx + 5'd1) : dx[3:0];
  assign ady  = dy[4] ? 4'(~dy + 5'd1) : dy[3:0];
  assign sqx  = {4'b0000, adx} * {4'b0000, adx};
  assign sqy  = {4'b0000, ady} * {4'b0000, ady};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      fill_cnt   <= '0;
      fill_free  <= 1'b0;
      dx         <= '0;
      dy         <= '0;
      rd_in_grid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        ox         <= cell_x;
        oy         <= cell_y;
        rd_in_grid <= center_in;
        if (action == ACT_MARK && center_in) begin
          dx <= -rs;
          dy <= -rs;
        end
        if (action == ACT_CLEAR) begin
          fill_cnt  <= '0;
          fill_free <= 1'b1;
        end
      end
      if (state == ST_INIT || state == ST_FILL) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (state == ST_SWEEP) begin
        if (sweep_done) begin
          dx <= '0;
          dy <= '0;
        end else if (last_col) begin
          dx <= -rs;
          dy <= dy + 5'sd1;
        end else begin
          dx <= dx + 5'sd1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT, ST_FILL: begin
        if (fill_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_CLEAR: state_next = ST_FILL;
            ACT_MARK:  state_next = center_in ? ST_SWEEP : ST_IDLE;
            ACT_READ:  state_next = ST_READ;
            ACT_TABLE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sweep_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_IDLE;
      ST_READ: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    fill_we       = (state == ST_INIT) || (state == ST_FILL);
    fill_addr     = fill_cnt;
    fill_val      = fill_free ? COST_FREE : COST_UNKNOWN;
    rd_load       = (state == ST_READ) && out_free;
    probe.valid   = (state == ST_SWEEP);
    probe.center  = (dx == 5'sd0) && (dy == 5'sd0);
    probe.in_grid = n_in;
    tbl_raddr     = {1'b0, sqx} + {1'b0, sqy};
    unique case (state)
      ST_IDLE:  grid_raddr = {YW'(cell_y), XW'(cell_x)};
      ST_SWEEP: grid_raddr = {YW'(ny[8:0]), XW'(nx[8:0])};
      default:  grid_raddr = {YW'(oy), XW'(ox)};
    endcase
  end

endmodule

[design/cmoi_update.sv]
// Update stage: takes the registered grid and table reads of one probe and
// writes back the raised cost or, at the center, lethal. Depends on cmoi_pkg.
`timescale 1ns / 1ps

module cmoi_update #(
  parameter int AW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmoi_pkg::probe_t      probe,
  input  logic [AW-1:0]         probe_addr,
  input  logic [7:0]            cur_cost,
  input  logic [6:0]            tbl_cost,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [7:0]            wdata
);

  import cmoi_pkg::*;

  probe_t        probe_q;
  logic [AW-1:0] addr_q;
  logic          raise;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe;
    end
    addr_q <= probe_addr;
  end

  // Raise to the table cost; a zero cost lies beyond the radius
  assign raise = (tbl_cost != 7'd0) && ($signed(cur_cost) < $signed({1'b0, tbl_cost}));

  assign we    = probe_q.valid && probe_q.in_grid && (probe_q.center || raise);
  assign waddr = addr_q;
  assign wdata = probe_q.center ? COST_LETHAL : {1'b0, tbl_cost};

endmodule

[dv/costmap_obstacle_inflation_tb.sv]
// Self-checking testbench for costmap_obstacle_inflation: a shadow cost map and decay
// table predict every read, with random sender bursts and receiver stalls.
// Depends on cmoi_pkg and the costmap_obstacle_inflation RTL.
`timescale 1ns / 1ps

module costmap_obstacle_inflation_tb;
  import cmoi_pkg::*;

  localparam int MAP_W        = 256;
  localparam int MAP_H        = 256;
  localparam int MAP_R        = 15;
  localparam int CYCLE_LIMIT  = 10000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 45;
  localparam int RANDOM_CLEARS = 3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] x;
    logic [7:0] y;
    logic [8:0] tidx;
    logic [6:0] tcost;
  } cell_item_t;

  typedef struct {
    logic signed [7:0] cost;
    logic              in_grid;
    int                x;
    int                y;
  } read_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_DENSE} rx_mode_t;

  // DUT-facing signals; every input of the DUT is known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [8:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = '0;
  logic [7:0]        cell_x = '0;
  logic [7:0]        cell_y = '0;
  logic [8:0]        table_index = '0;
  logic [6:0]        table_cost = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [7:0] cell_cost;
  logic              read_in_grid;

  // Shadow state of the block
  logic signed [7:0] shadow_map [0:MAP_W*MAP_H-1];
  logic [6:0]        shadow_decay [0:TABLE_DEPTH-1];
  logic [8:0]        shadow_width = 9'd256;
  logic [8:0]        shadow_height = 9'd256;
  logic [3:0]        shadow_radius = 4'd0;

  read_result_t pending_reads [$];

  // Bookkeeping
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int busy_tail = 0;       // cycles of non-read work queued since the last read
  int hold_requests = 0;
  int reads_checked = 0;
  int marks_sent = 0;
  int clears_sent = 0;
  int table_sent = 0;
  int clears_left = RANDOM_CLEARS;
  int recent_x [$];
  int recent_y [$];

  costmap_obstacle_inflation DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .table_index  (table_index),
    .table_cost   (table_cost),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_cost    (cell_cost),
    .read_in_grid (read_in_grid)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d reads outstanding", cycle_count,
               pending_reads.size());
      $display("costmap_obstacle_inflation_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------
  function automatic int used_width();
    if (shadow_width == 0) return 1;
    if (shadow_width > MAP_W) return MAP_W;
    return shadow_width;
  endfunction

  function automatic int used_height();
    if (shadow_height == 0) return 1;
    if (shadow_height > MAP_H) return MAP_H;
    return shadow_height;
  endfunction

  function automatic int used_radius();
    if (shadow_radius > MAP_R) return MAP_R;
    return shadow_radius;
  endfunction

  function automatic void fill_shadow(logic signed [7:0] v);
    for (int i = 0; i < MAP_W * MAP_H; i++) shadow_map[i] = v;
  endfunction

  // Set the obstacle lethal, then raise each in-grid neighbor to its decay cost
  function automatic void stamp_obstacle(int ox, int oy);
    int w, h, r, nx, ny, d2, c, idx;
    w = used_width();
    h = used_height();
    r = used_radius();
    if (ox >= w || oy >= h) return;
    shadow_map[oy * MAP_W + ox] = COST_LETHAL;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        nx = ox + dx;
        ny = oy + dy;
        if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
        d2 = dx * dx + dy * dy;
        c = (d2 < TABLE_DEPTH) ? int'(shadow_decay[d2]) : 0;
        // zero cost means beyond the radius: leave the cell alone
        if (c == 0) continue;
        idx = ny * MAP_W + nx;
        if (c > int'(shadow_map[idx])) shadow_map[idx] = 8'(c);
      end
    end
  endfunction

  // Advance the shadow state by one accepted transaction
  function automatic void costmap_predict(cell_item_t it);
    read_result_t r;
    int r_eff;
    case (it.action)
      ACT_CLEAR: begin
        fill_shadow(COST_FREE);
        clears_sent++;
        busy_tail += MAP_W * MAP_H + 1;
      end
      ACT_MARK: begin
        stamp_obstacle(it.x, it.y);
        marks_sent++;
        r_eff = used_radius();
        busy_tail += (2 * r_eff + 1) * (2 * r_eff + 1) + 2;
      end
      ACT_TABLE: begin
        shadow_decay[it.tidx] = (it.tcost > TABLE_LETHAL) ? TABLE_LETHAL : it.tcost;
        table_sent++;
        busy_tail += 1;
      end
      default: begin
        r.x = it.x;
        r.y = it.y;
        if (int'(it.x) < used_width() && int'(it.y) < used_height()) begin
          r.cost    = shadow_map[int'(it.y) * MAP_W + int'(it.x)];
          r.in_grid = 1'b1;
        end else begin
          r.cost    = COST_UNKNOWN;
          r.in_grid = 1'b0;
        end
        pending_reads = {pending_reads, r};
        // everything ahead of a read has finished once its result shows up
        busy_tail = 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int x, int y, int got, int want);
    $display("MISMATCH %s at cell (%0d,%0d): got %0d, expected %0d (t=%0t)",
             what, x, y, got, want, $time);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    read_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected result", -1, -1, cell_cost, 0);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (cell_cost !== want.cost)
          report_mismatch("cell_cost", want.x, want.y, cell_cost, want.cost);
        if (read_in_grid !== want.in_grid)
          report_mismatch("read_in_grid", want.x, want.y, read_in_grid, want.in_grid);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a stall pattern that is redrawn from four random modes, plus long
  // hold-offs on request from the stimulus
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       hold_left = 0;
  int       holds_served = 0;

  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------
  function automatic cell_item_t make_item(logic [1:0] act, int x, int y,
                                           int tidx, int tcost);
    cell_item_t it;
    it.action = act;
    it.x      = 8'(x);
    it.y      = 8'(y);
    it.tidx   = 9'(tidx);
    it.tcost  = 7'(tcost);
    return it;
  endfunction

  // Offer one transaction; bursts of random length, mostly with idle gaps between
  task automatic send_item(cell_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= it.action;
    cell_x      <= it.x;
    cell_y      <= it.y;
    table_index <= it.tidx;
    table_cost  <= it.tcost;
    do @(posedge clk); while (in_ready !== 1'b1);
    burst_left--;
    costmap_predict(it);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [8:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  shadow_width  = data;
      CFG_GRID_HEIGHT: shadow_height = data;
      CFG_INFLATION:   shadow_radius = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int w, int h, int r);
    write_cfg(CFG_GRID_WIDTH, 9'(w));
    write_cfg(CFG_GRID_HEIGHT, 9'(h));
    write_cfg(CFG_INFLATION, 9'(r));
  endtask

  // Wait for every read result, then let any trailing clear/mark work finish
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (busy_tail + 20) @(posedge clk);
    busy_tail = 0;
  endtask

  task automatic send_read(int x, int y);
    send_item(make_item(ACT_READ, x, y, 0, 0));
  endtask

  task automatic send_mark(int x, int y);
    send_item(make_item(ACT_MARK, x, y, 0, 0));
  endtask

  function automatic int clamp_cell(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Mostly marks in the grid and reads around recent marks, some noise
  task automatic send_random_item();
    int pick, k, r, x, y;
    pick = $urandom_range(0, 99);
    r = used_radius();
    if (pick < 40) begin
      x = $urandom_range(0, used_width() - 1);
      y = $urandom_range(0, used_height() - 1);
      send_mark(x, y);
      recent_x = {recent_x, x};
      recent_y = {recent_y, y};
      if (recent_x.size() > 8) begin
        void'(recent_x.pop_front());
        void'(recent_y.pop_front());
      end
    end else if (pick < 80) begin
      if (recent_x.size() == 0) begin
        x = $urandom_range(0, used_width() - 1);
        y = $urandom_range(0, used_height() - 1);
      end else begin
        k = $urandom_range(0, recent_x.size() - 1);
        x = clamp_cell(recent_x[k] + $urandom_range(0, 2 * r + 2) - (r + 1));
        y = clamp_cell(recent_y[k] + $urandom_range(0, 2 * r + 2) - (r + 1));
      end
      send_read(x, y);
    end else if (pick < 88) begin
      // noise: any coordinates, any don't-care fields
      send_item(make_item(($urandom_range(0, 1) != 0) ? ACT_READ : ACT_MARK,
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 511), $urandom_range(0, 127)));
    end else if (pick < 97 || clears_left == 0) begin
      if (pick >= 97) begin
        send_read($urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        send_item(make_item(ACT_TABLE, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 511), $urandom_range(0, 127)));
      end
    end else begin
      clears_left--;
      send_item(make_item(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 511), $urandom_range(0, 127)));
    end
  endtask

  function automatic int pick_extent();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 256;
      3:       return $urandom_range(257, 511);
      4:       return $urandom_range(2, 16);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  function automatic int pick_radius();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return $urandom_range(0, 4);
    if (p < 85) return $urandom_range(5, 10);
    return $urandom_range(11, 15);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at their reset values; every cell starts unknown
  task automatic test_power_on();
    set_geometry(256, 256, 0);
    send_read(0, 0);
    send_read(255, 255);
    send_read(37, 200);
    drain_and_settle();
  endtask

  // Load every entry a sweep can reach so none is ever read unwritten
  task automatic test_decay_table_load();
    int c;
    bit reach [TABLE_DEPTH];
    for (int a = 0; a <= MAP_R; a++) begin
      for (int b = 0; b <= MAP_R; b++) reach[a * a + b * b] = 1'b1;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!reach[i]) continue;
      c = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127);
      if (i == 0) c = 127;  // above lethal, must saturate
      send_item(make_item(ACT_TABLE, $urandom_range(0, 255), $urandom_range(0, 255), i, c));
    end
    drain_and_settle();
  endtask

  task automatic test_directed();
    // Stamp on an unknown grid: zero-cost entries must leave cells unknown
    set_geometry(256, 256, 1);
    send_item(make_item(ACT_TABLE, 0, 0, 0, 127));
    send_item(make_item(ACT_TABLE, 0, 0, 1, 101));
    send_item(make_item(ACT_TABLE, 0, 0, 2, 0));
    send_mark(10, 10);
    send_read(10, 10);
    send_read(11, 10);
    send_read(11, 11);
    send_read(12, 10);
    // corner obstacle: neighbors off the grid are skipped
    send_mark(255, 255);
    send_read(255, 255);
    send_read(254, 255);
    drain_and_settle();

    // Width saturates up from 0, height down from 511, widest sweep
    set_geometry(0, 511, 15);
    send_item(make_item(ACT_CLEAR, 0, 0, 0, 0));
    send_mark(0, 128);
    send_mark(1, 0);          // outside the grid, dropped
    send_read(1, 0);          // outside the grid
    send_read(0, 128);
    send_read(0, 140);
    send_read(0, 255);
    drain_and_settle();

    // Single-row grid
    set_geometry(256, 1, 15);
    send_mark(255, 0);
    send_read(240, 0);
    send_read(255, 0);
    send_read(0, 1);
    send_read(255, 255);
    drain_and_settle();
  endtask

  task automatic test_random_phases();
    int r;
    for (int p = 0; p < 6; p++) begin
      r = pick_radius();
      // upper bits of the inflation write are ignored by the register
      if (p % 2 == 1) r = r | ($urandom_range(0, 31) << 4);
      set_geometry(pick_extent(), pick_extent(), r);
      recent_x.delete();
      recent_y.delete();
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      drain_and_settle();
    end
  endtask

  // Hold off the receiver long enough that reads back up into the input,
  // then let the sender wait for every result before carrying on
  task automatic test_output_backpressure();
    set_geometry(256, 256, 2);
    recent_x.delete();
    recent_y.delete();
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 0) send_mark($urandom_range(0, 255), $urandom_range(0, 255));
      else send_read($urandom_range(0, 255), $urandom_range(0, 255));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    for (int i = 0; i < 30; i++) send_random_item();
    drain_and_settle();
  endtask

  initial begin
    fill_shadow(COST_UNKNOWN);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_on();
    test_decay_table_load();
    test_directed();
    test_random_phases();
    test_output_backpressure();
    drain_and_settle();

    if (pending_reads.size() != 0)
      report_mismatch("missing results", -1, -1, pending_reads.size(), 0);

    $display("Covered %0d marks, %0d clears, %0d table writes and %0d checked reads",
             marks_sent, clears_sent, table_sent, reads_checked);
    $display("across many grid sizes and sweep radii in %0d cycles, %0d mismatches",
             cycle_count, error_count);
    if (error_count == 0) begin
      $display("costmap_obstacle_inflation_tb: clean");
    end else begin
      $display("costmap_obstacle_inflation_tb: errors");
    end
    $finish;
  end

endmodule

[costmap_obstacle_inflation.f]
design/cmoi_pkg.sv
design/cmoi_ram.sv
design/cmoi_ctrl.sv
design/cmoi_update.sv
design/costmap_obstacle_inflation.sv
dv/costmap_obstacle_inflation_tb.sv
